### rtl/wrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wrt_pkg;
	localparam int MaxSegments = 64;
	localparam int AddrBits = 32;
	localparam int IdxBits = $clog2(MaxSegments);
	localparam int CntBits = $clog2(MaxSegments + 1);
	localparam int ScrDepth = 2 * MaxSegments + 4;
	localparam int ScrBits = $clog2(ScrDepth + 1);
	localparam int ScrIdxBits = $clog2(ScrDepth);

	typedef logic [AddrBits-1:0] addr_t;
	typedef logic [1:0] flags_t;

	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_REMOVE = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// classified command handed from front to back
	typedef struct packed {
		logic [1:0] action;
		logic active;
		addr_t rs;
		addr_t re;
		flags_t q;
	} cmd_t;

	typedef struct packed {
		logic [6:0] hit_count;
		logic table_full;
		logic [6:0] segments_used;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_PIECE, ST_TAIL, ST_COPY, ST_DONE
	} bstate_t;
endpackage
`default_nettype wire

### rtl/wrt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface wrt_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [31:0] start_address;
	logic [31:0] range_length;
	logic [1:0] watch_flags;
	modport source(output valid, action, start_address, range_length, watch_flags,
		input ready);
	modport sink(input valid, action, start_address, range_length, watch_flags,
		output ready);
endinterface

interface wrt_out_if;
	logic valid;
	logic ready;
	logic [6:0] hit_count;
	logic table_full;
	logic [6:0] segments_used;
	modport source(output valid, hit_count, table_full, segments_used, input ready);
	modport sink(input valid, hit_count, table_full, segments_used, output ready);
endinterface
`default_nettype wire

### rtl/wrt_front.sv
`timescale 1ns / 1ps
`default_nettype none
module wrt_front (
	input wire logic clk,
	input wire logic arst_n,
	wrt_in_if.sink in_ch,
	output wrt_pkg::cmd_t cmd,
	output logic cmd_valid,
	input wire logic cmd_ready
);
	import wrt_pkg::*;
	// two-entry queue
	cmd_t q_mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	cmd_t c;
	logic [AddrBits:0] sum;
	addr_t amask;

	always_comb begin
		amask = '1;
		sum = {1'b0, in_ch.start_address[AddrBits-1:0]}
			+ {1'b0, in_ch.range_length[AddrBits-1:0]};
		c.action = in_ch.action;
		c.rs = in_ch.start_address[AddrBits-1:0];
		c.q = in_ch.watch_flags;
		// saturate end below the top byte
		c.re = (sum >= {1'b0, amask}) ? amask : sum[AddrBits-1:0];
		c.active = (c.re > c.rs) && (c.q != 2'b00) && (in_ch.action != 2'd3);
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) q_mem_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_ch.valid && in_ch.ready) wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, in_ch.valid && in_ch.ready}
				- {1'b0, cmd_valid && cmd_ready};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !(cmd_valid && cmd_ready)) |=> cnt_q == 2'd2)
		else $error("full queue drained without transaction");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0) |=> !(cmd_valid && cmd_ready) || $past(in_ch.valid))
		else $error("empty queue popped");
endmodule
`default_nettype wire

### rtl/wrt_back.sv
`timescale 1ns / 1ps
`default_nettype none
module wrt_back (
	input wire logic clk,
	input wire logic arst_n,
	input wrt_pkg::cmd_t cmd,
	input wire logic cmd_valid,
	output logic cmd_ready,
	wrt_out_if.source out_ch
);
	import wrt_pkg::*;
	localparam logic [CntBits-1:0] CntMax = CntBits'(MaxSegments);
	localparam logic [ScrBits-1:0] ScrMax = ScrBits'(ScrDepth);

	// segment table stored as [lo, hi)
	addr_t tlo_mem [MaxSegments];
	addr_t thi_mem [MaxSegments];
	flags_t tfl_mem [MaxSegments];
	addr_t slo_mem [ScrDepth];
	addr_t shi_mem [ScrDepth];
	flags_t sfl_mem [ScrDepth];

	bstate_t st_q, st_d;
	cmd_t c_q;
	logic [CntBits-1:0] count_q, i_q;
	logic [ScrBits-1:0] scr_n_q;
	logic over_q;
	addr_t cursor_q;
	addr_t s_q, e_q;
	flags_t f_q;
	logic [2:0] piece_q;
	logic [6:0] hits_q;
	addr_t last_hi_q;
	flags_t last_fl_q;
	res_t res_q;
	logic out_v_q;
	logic rd_seg_s1;

	// registered reads; hold the segment while its pieces are walked
	always_ff @(posedge clk) begin
		if (st_q == ST_READ) begin
			s_q <= tlo_mem[i_q[IdxBits-1:0]];
			e_q <= thi_mem[i_q[IdxBits-1:0]];
			f_q <= tfl_mem[i_q[IdxBits-1:0]];
		end
	end
	addr_t cs_q, ce_q;
	flags_t cf_q;
	always_ff @(posedge clk) begin
		cs_q <= slo_mem[ScrIdxBits'(i_q)];
		ce_q <= shi_mem[ScrIdxBits'(i_q)];
		cf_q <= sfl_mem[ScrIdxBits'(i_q)];
	end

	logic adding;
	flags_t inner;
	addr_t p_lo, p_hi;
	flags_t p_fl;
	logic emit, do_merge, do_push;
	logic [ScrBits-1:0] scr_n_d;
	logic over_d, reject;
	assign adding = (c_q.action == ACT_ADD);
	assign inner = adding ? (f_q | c_q.q) : (f_q & ~c_q.q);

	always_comb begin
		p_lo = '0;
		p_hi = '0;
		p_fl = '0;
		case (piece_q)
			3'd0: begin
				p_lo = cursor_q;
				p_hi = (s_q < c_q.re) ? s_q : c_q.re;
				p_fl = (adding && s_q > cursor_q && cursor_q < c_q.re) ? c_q.q : 2'b00;
			end
			3'd1: begin
				p_lo = s_q;
				p_hi = (e_q < c_q.rs) ? e_q : c_q.rs;
				p_fl = f_q;
			end
			3'd2: begin
				p_lo = (s_q > c_q.rs) ? s_q : c_q.rs;
				p_hi = (e_q < c_q.re) ? e_q : c_q.re;
				p_fl = inner;
			end
			3'd3: begin
				p_lo = (s_q > c_q.re) ? s_q : c_q.re;
				p_hi = e_q;
				p_fl = f_q;
			end
			default: begin
				p_lo = cursor_q;
				p_hi = c_q.re;
				p_fl = (adding && cursor_q < c_q.re) ? c_q.q : 2'b00;
			end
		endcase
		emit = (p_fl != 2'b00) && (p_hi > p_lo)
			&& (st_q == ST_PIECE || st_q == ST_TAIL);
		do_merge = emit && (scr_n_q != '0) && (last_hi_q == p_lo) && (last_fl_q == p_fl);
		do_push = emit && !do_merge && (scr_n_q < ScrMax);
		// count the tail piece that lands in the same cycle as the check
		scr_n_d = do_push ? scr_n_q + 1'b1 : scr_n_q;
		over_d = over_q || (emit && !do_merge && !do_push);
		reject = over_d || (scr_n_d > ScrBits'(MaxSegments));
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slo_mem[scr_n_q[ScrIdxBits-1:0]] <= p_lo;
			shi_mem[scr_n_q[ScrIdxBits-1:0]] <= p_hi;
			sfl_mem[scr_n_q[ScrIdxBits-1:0]] <= p_fl;
		end else if (do_merge) begin
			shi_mem[ScrIdxBits'(scr_n_q - 1'b1)] <= p_hi;
		end
		if (rd_seg_s1) begin
			tlo_mem[i_q[IdxBits-1:0] - 1'b1] <= cs_q;
			thi_mem[i_q[IdxBits-1:0] - 1'b1] <= ce_q;
			tfl_mem[i_q[IdxBits-1:0] - 1'b1] <= cf_q;
		end
	end

	logic more;
	assign more = (i_q < count_q);

	always_comb begin
		st_d = st_q;
		cmd_ready = 1'b0;
		case (st_q)
			ST_IDLE: if (cmd_valid && !out_v_q) begin
				cmd_ready = 1'b1;
				st_d = cmd.active ? ST_READ : ST_DONE;
			end
			ST_READ: st_d = more ? ST_PIECE : (c_q.action == ACT_QUERY ? ST_DONE : ST_TAIL);
			ST_PIECE: if (c_q.action == ACT_QUERY || piece_q == 3'd3) st_d = ST_READ;
			ST_TAIL: st_d = reject ? ST_DONE : ST_COPY;
			ST_COPY: if (ScrBits'(i_q) > scr_n_q) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
			rd_seg_s1 <= 1'b0;
		end else begin
			st_q <= st_d;
			rd_seg_s1 <= (st_q == ST_COPY) && (ScrBits'(i_q) < scr_n_q);
			if (out_ch.valid && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (cmd_valid && !out_v_q) begin
					c_q <= cmd;
					i_q <= '0;
					scr_n_q <= '0;
					over_q <= 1'b0;
					cursor_q <= cmd.rs;
					hits_q <= '0;
					piece_q <= 3'd0;
					res_q.table_full <= 1'b0;
				end
				ST_READ: begin
					piece_q <= more ? 3'd0 : 3'd4;
					if (more) i_q <= i_q + 1'b1;
				end
				ST_PIECE: begin
					if (c_q.action == ACT_QUERY) begin
						if (s_q < c_q.re && e_q > c_q.rs && (f_q & c_q.q) != 2'b00)
							hits_q <= hits_q + 1'b1;
					end else begin
						piece_q <= piece_q + 1'b1;
						if (piece_q == 3'd3 && e_q > cursor_q) cursor_q <= e_q;
					end
				end
				ST_TAIL: begin
					i_q <= '0;
					res_q.table_full <= reject;
				end
				ST_COPY: begin
					i_q <= i_q + 1'b1;
					if (ScrBits'(i_q) > scr_n_q) count_q <= CntBits'(scr_n_q);
				end
				ST_DONE: begin
					out_v_q <= 1'b1;
					res_q.hit_count <= hits_q;
					res_q.segments_used <= 7'(count_q);
				end
				default: ;
			endcase
			if (do_push) scr_n_q <= scr_n_q + 1'b1;
			if (emit && !do_merge && !do_push) over_q <= 1'b1;
			if (do_merge || do_push) begin
				last_hi_q <= p_hi;
				last_fl_q <= p_fl;
			end
		end
	end

	assign out_ch.valid = out_v_q;
	assign out_ch.hit_count = res_q.hit_count;
	assign out_ch.table_full = res_q.table_full;
	assign out_ch.segments_used = res_q.segments_used;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CntMax)
		else $error("segment count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE) |=> out_v_q)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !cmd_ready)
		else $error("command taken while busy");
endmodule
`default_nettype wire

### rtl/watchpoint_range_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A query reads each stored segment and counts hits; an add or remove splits
// each segment into pieces, then copies the new table back (no copy if rejected).
// Throughput: one transaction at a time in the back end, set by the segment walk.
// A two-entry queue in the front keeps accepting while the walk runs, until full.
// Reset clears the FSM, queue and segment count; table contents stay undefined.
module watchpoint_range_table_core (
	input wire logic clk,
	input wire logic arst_n,
	wrt_in_if.sink in_ch,
	wrt_out_if.source out_ch
);
	import wrt_pkg::*;
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	wrt_front u_front (.clk, .arst_n, .in_ch, .cmd, .cmd_valid, .cmd_ready);
	wrt_back u_back (.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready, .out_ch);
endmodule
`default_nettype wire
